>>> hdl/scdec_pkg.sv
// Shared types, constants and the set 1 make code table for the scan code decoder.
`default_nettype none

package scdec_pkg;

  localparam int unsigned SCDEC_QUEUE_DEPTH = 64;

  localparam logic [7:0] PREFIX_EXT = 8'hE0;
  localparam logic [7:0] BREAK_BIT  = 8'h80;

  localparam logic OP_SCAN = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam int unsigned LEVEL_W = 6;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_READ
  } scdec_state_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;   // take the item on the input port this cycle
    logic capture;  // load the read data of a pop into the result
  } scdec_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic pop_hit;  // item on the input port is a pop and the queue holds something
  } scdec_stat_t;

  // Set 1 make code to ASCII; letters upper case, zero for unmapped codes.
  function automatic logic [6:0] decode_make(input logic [7:0] code);
    logic [6:0] ch;
    unique case (code)
      8'h02: ch = 7'h31;
      8'h03: ch = 7'h32;
      8'h04: ch = 7'h33;
      8'h05: ch = 7'h34;
      8'h06: ch = 7'h35;
      8'h07: ch = 7'h36;
      8'h08: ch = 7'h37;
      8'h09: ch = 7'h38;
      8'h0A: ch = 7'h39;
      8'h0B: ch = 7'h30;
      8'h0C: ch = 7'h2D;
      8'h0E: ch = 7'h08;
      8'h10: ch = 7'h51;
      8'h11: ch = 7'h57;
      8'h12: ch = 7'h45;
      8'h13: ch = 7'h52;
      8'h14: ch = 7'h54;
      8'h15: ch = 7'h59;
      8'h16: ch = 7'h55;
      8'h17: ch = 7'h49;
      8'h18: ch = 7'h4F;
      8'h19: ch = 7'h50;
      8'h1C: ch = 7'h0A;
      8'h1E: ch = 7'h41;
      8'h1F: ch = 7'h53;
      8'h20: ch = 7'h44;
      8'h21: ch = 7'h46;
      8'h22: ch = 7'h47;
      8'h23: ch = 7'h48;
      8'h24: ch = 7'h4A;
      8'h25: ch = 7'h4B;
      8'h26: ch = 7'h4C;
      8'h2C: ch = 7'h5A;
      8'h2D: ch = 7'h58;
      8'h2E: ch = 7'h43;
      8'h2F: ch = 7'h56;
      8'h30: ch = 7'h42;
      8'h31: ch = 7'h4E;
      8'h32: ch = 7'h4D;
      8'h39: ch = 7'h20;
      default: ch = 7'h00;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

>>> hdl/scdec_dp.sv
// Datapath: prefix flag, character queue with pointers, and the result register.
`default_nettype none

module scdec_dp
  import scdec_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = SCDEC_QUEUE_DEPTH
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire scdec_cmd_t   cmd,
  output scdec_stat_t       stat,
  input  wire logic         opcode,
  input  wire logic [7:0]   scan_byte,
  output logic [6:0]        key_char,
  output logic              key_valid,
  output logic              dropped,
  output logic [LEVEL_W-1:0] queue_level
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned EXT_W = (PTR_W > LEVEL_W) ? PTR_W : LEVEL_W;
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [PTR_W:0]   DEPTH_X   = (PTR_W + 1)'(QUEUE_DEPTH);

  logic [6:0] mem [QUEUE_DEPTH];

  logic             ext_r, ext_nxt;
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [6:0]       rd_data_r;
  logic [6:0]       char_r;
  logic             valid_r;
  logic             drop_r;
  logic [LEVEL_W-1:0] level_r;

  logic             empty;
  logic             pop_hit;
  logic [6:0]       dec_ch;
  logic             push_try;
  logic             full;
  logic             do_push;
  logic             lost;
  logic [PTR_W-1:0] wptr_inc;
  logic [PTR_W-1:0] rptr_inc;
  logic [PTR_W:0]   diff;
  logic [EXT_W-1:0] level_ext;

  assign empty    = (wptr_r == rptr_r);
  assign pop_hit  = (opcode == OP_POP) && !empty;
  assign stat.pop_hit = pop_hit;

  assign wptr_inc = (wptr_r == LAST_SLOT) ? '0 : wptr_r + 1'b1;
  assign rptr_inc = (rptr_r == LAST_SLOT) ? '0 : rptr_r + 1'b1;
  assign full     = (wptr_inc == rptr_r);
  assign dec_ch   = decode_make(scan_byte);

  always_comb begin
    ext_nxt  = ext_r;
    push_try = 1'b0;
    if (opcode == OP_SCAN) begin
      priority if (scan_byte == PREFIX_EXT) begin
        ext_nxt = 1'b1;
      end else if (ext_r) begin
        ext_nxt = 1'b0;
      end else if ((scan_byte & BREAK_BIT) == '0) begin
        push_try = (dec_ch != '0);
      end else begin
        push_try = 1'b0;  // break code, ignored
      end
    end
  end

  assign do_push  = push_try && !full;
  assign lost     = push_try && full;
  assign wptr_nxt = do_push ? wptr_inc : wptr_r;
  assign rptr_nxt = pop_hit ? rptr_inc : rptr_r;

  // occupancy after this item, modulo the queue depth
  always_comb begin
    diff = {1'b0, wptr_nxt} - {1'b0, rptr_nxt};
    if (wptr_nxt < rptr_nxt) begin
      diff = diff + DEPTH_X;
    end
    level_ext = EXT_W'(diff[PTR_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_r  <= 1'b0;
      wptr_r <= '0;
      rptr_r <= '0;
    end else if (cmd.accept) begin
      ext_r  <= ext_nxt;
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && do_push) begin
      mem[wptr_r] <= dec_ch;
    end
    if (cmd.accept) begin
      rd_data_r <= mem[rptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      char_r  <= '0;
      valid_r <= pop_hit;
      drop_r  <= lost;
      level_r <= level_ext[LEVEL_W-1:0];
    end else if (cmd.capture) begin
      char_r  <= rd_data_r;
    end
  end

  assign key_char    = char_r;
  assign key_valid   = valid_r;
  assign dropped     = drop_r;
  assign queue_level = level_r;

endmodule

`default_nettype wire

>>> hdl/scdec_ctrl.sv
// Controller: input/output handshakes and the pop read sequencing.
`default_nettype none

module scdec_ctrl
  import scdec_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  input  wire scdec_stat_t stat,
  output scdec_cmd_t       cmd
);

  scdec_state_t state_r, state_nxt;
  logic         ovalid_r, ovalid_nxt;
  logic         slot_free;
  logic         acc;

  assign slot_free = !ovalid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && slot_free;
  assign acc       = in_tvalid && in_tready;

  always_comb begin
    state_nxt   = state_r;
    ovalid_nxt  = ovalid_r;
    cmd.accept  = 1'b0;
    cmd.capture = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (out_tready) begin
          ovalid_nxt = 1'b0;
        end
        if (acc) begin
          cmd.accept = 1'b1;
          if (stat.pop_hit) begin
            state_nxt  = ST_READ;
            ovalid_nxt = 1'b0;
          end else begin
            ovalid_nxt = 1'b1;
          end
        end
      end
      ST_READ: begin
        cmd.capture = 1'b1;
        ovalid_nxt  = 1'b1;
        state_nxt   = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  assign out_tvalid = ovalid_r;

endmodule

`default_nettype wire

>>> hdl/scancode_decoder_with_key_fifo.sv
// Top level: PS/2 set 1 scan code decoder feeding a character queue.
//
//  Channel  Dir  Ports                      Payload
//  in_      in   tvalid tready tdata tuser  tdata[7:0] scan_byte, tuser[0] opcode
//  out_     out  tvalid tready tdata tuser  tdata key_char/dropped/queue_level,
//                                           tuser[0] key_valid
//
//  Scan byte items and pops on an empty queue show their result the cycle
//  after acceptance. A pop that hits passes through ST_READ first, for the
//  registered read of the character memory.
//  Reset (rst_n low, synchronous) clears the prefix flag and both pointers;
//  the memory contents are left alone.
//  A new item is taken while a result waits only if out_tready is high that
//  cycle; otherwise in_tready stays low until the result is taken.
`default_nettype none

module scancode_decoder_with_key_fifo
  import scdec_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = SCDEC_QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] scan_byte
  input  wire logic        in_tuser,   // [0] opcode (0 scan byte, 1 pop)
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [6:0] key_char, [7] dropped,
                                       // [13:8] queue_level, [15:14] zero
  output logic             out_tuser   // [0] key_valid
);

  scdec_cmd_t  cmd;
  scdec_stat_t stat;

  logic [6:0]         key_char;
  logic               key_valid;
  logic               dropped;
  logic [LEVEL_W-1:0] queue_level;

  scdec_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  scdec_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .opcode      (in_tuser),
    .scan_byte   (in_tdata),
    .key_char    (key_char),
    .key_valid   (key_valid),
    .dropped     (dropped),
    .queue_level (queue_level)
  );

  // pack the result item; the top two bits pad to whole bytes
  assign out_tdata = {2'b00, queue_level, dropped, key_char};
  assign out_tuser = key_valid;

endmodule

`default_nettype wire

>>> hdl/scdec_chk.sv
// Port-level checker for the scan code decoder, bound to the top level.
`default_nettype none

module scdec_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata,
  input wire logic        out_tuser
);

  // a waiting result must not be dropped
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result withdrawn while stalled");

  // no new item while a stalled result occupies the output register
  a_no_take_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("item taken while output blocked");

  // a popped character is always a mapped, nonzero code
  a_valid_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[6:0] != 7'h00)
    else $error("valid pop with zero character");

  // pop results never report a loss, and the pad bits stay clear
  a_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser && out_tdata[7]) && out_tdata[15:14] == 2'b00)
    else $error("inconsistent result fields");

endmodule

bind scancode_decoder_with_key_fifo scdec_chk u_scdec_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
